// File: hdl/mps_pkg.sv
// mps_pkg: shared types and constants of the memory pattern search block
// used by mps_cell, mps_rfifo, memory_pattern_search and mps_checker
// depends on nothing
package mps_pkg;

	// configuration register indexes
	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] CFG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_REGION_BASE    = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_REPORT_ALL     = 2'd2;

	localparam int CFG_DW = 32;
	localparam int LEN_W  = 9;
	localparam int ADDR_W = 32;

	// input command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SCAN = 1'b1;

	// result kinds
	localparam logic KIND_MATCH = 1'b0;
	localparam logic KIND_END   = 1'b1;

	// address of an end report when the region had no match
	localparam logic [ADDR_W-1:0] NO_ADDRESS = 32'hffff_ffff;

	// result queue depth, room for the two words one byte can cause plus slack
	localparam int FIFO_DEPTH = 4;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] match_address;
		logic              any_found;
		logic              last;
	} result_t;

	// controls broadcast to every cell of the chain
	typedef struct packed {
		logic shift;  // take the feed byte, advance window and match bits
		logic clear;  // empty the match bits after this step
	} cell_ctrl_t;

endpackage

// File: hdl/mps_cell.sv
// mps_cell: one position of the search chain, holds a pattern byte,
// a window byte and the prefix match bit for that position
// depends on mps_pkg
module mps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  mps_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]          feed,
	input  logic                load_en,
	input  logic [7:0]          load_byte,
	input  logic [7:0]          win_in,
	input  logic                mat_in,
	output logic [7:0]          win_q,
	output logic                mat_q,
	output logic                mat_next
);

	logic [7:0] pat_q;

	// pattern prefix ending here holds if the shorter prefix held one byte ago
	assign mat_next = mat_in & (feed == pat_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= 1'b0;
		end else if (ctrl.shift) begin
			mat_q <= ctrl.clear ? 1'b0 : mat_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			pat_q <= load_byte;
		end
		if (ctrl.shift) begin
			win_q <= win_in;
		end
	end

endmodule

// File: hdl/mps_rfifo.sv
// mps_rfifo: small result queue, takes up to two words a cycle, gives one
// depends on mps_pkg
module mps_rfifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push0,
	input  mps_pkg::result_t word0,
	input  logic             push1,
	input  mps_pkg::result_t word1,
	input  logic             pop,
	output logic             room2,
	output logic             nonempty,
	output mps_pkg::result_t head
);

	localparam int PW = $clog2(mps_pkg::FIFO_DEPTH);
	localparam int CW = $clog2(mps_pkg::FIFO_DEPTH + 1);

	mps_pkg::result_t        entry_q [mps_pkg::FIFO_DEPTH];
	logic [PW-1:0]           wr_ptr_q;
	logic [PW-1:0]           rd_ptr_q;
	logic [CW-1:0]           count_q;
	logic [PW-1:0]           wr_ptr_p1;
	logic [CW-1:0]           count_next;

	assign wr_ptr_p1 = wr_ptr_q + PW'(1);
	assign nonempty  = (count_q != '0);
	assign room2     = (count_q <= CW'(mps_pkg::FIFO_DEPTH - 2));
	assign head      = entry_q[rd_ptr_q];

	assign count_next = count_q + CW'(push0) + CW'(push1) - CW'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push0) + PW'(push1);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			entry_q[wr_ptr_q] <= word0;
		end
		if (push1) begin
			entry_q[wr_ptr_p1] <= word1;
		end
	end

endmodule

// File: hdl/memory_pattern_search.sv
// memory_pattern_search: streaming byte pattern search over a memory region
// built from a chain of mps_cell positions and an mps_rfifo result queue
// depends on mps_pkg, mps_cell, mps_rfifo
//
//   channel   direction  handshake              word
//   item      in         item_valid/item_stall  command, data_byte, last_byte
//   result    out        result_valid/stall     kind, match_address, any_found, last
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one item per cycle while item_stall is low: every cell compares the incoming
// byte against its own pattern byte and hands its prefix match bit to the next
// cell, so a scan byte is fully resolved in the cycle it is taken
// results sit in a four word queue; item_stall rises while fewer than two slots are free
// a pattern byte loaded in the middle of a region makes the next scan byte wait
// while the window is rotated once through the chain to rebuild the match bits
// against the new pattern
// asynchronous reset clears control state and queue; config resets, pattern length to one
module memory_pattern_search #(
	parameter int MAX_PATTERN = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// item channel
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic                       command,
	input  logic [7:0]                 data_byte,
	input  logic                       last_byte,
	// result channel
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic                       kind,
	output logic [mps_pkg::ADDR_W-1:0] match_address,
	output logic                       any_found,
	output logic                       last,
	// configuration channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mps_pkg::CFG_IW-1:0] cfg_index,
	input  logic [mps_pkg::CFG_DW-1:0] cfg_data
);

	// cell index width and a width that also holds MAX_PATTERN itself
	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int FW = $clog2(MAX_PATTERN + 1);

	// configuration
	logic [mps_pkg::LEN_W-1:0]  pattern_length_q;
	logic [mps_pkg::ADDR_W-1:0] region_base_q;
	logic                       report_all_q;

	// scan state
	logic                       active_q;     // a region is under way
	logic [mps_pkg::ADDR_W-1:0] scan_addr_q;
	logic [FW-1:0]              fill_q;       // bytes in the window since last clear
	logic                       found_q;
	logic [mps_pkg::ADDR_W-1:0] hit_addr_q;
	logic [FW-1:0]              load_idx_q;

	// rebuild of the match bits after a pattern change mid-region
	logic                       dirty_q;
	logic                       replay_q;
	logic [IW-1:0]              rep_cnt_q;

	// chain wiring
	logic [7:0]                 win  [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]     mat;
	logic [MAX_PATTERN-1:0]     mat_next;
	logic [MAX_PATTERN-1:0]     chain_in;
	mps_pkg::cell_ctrl_t        ctrl;
	logic [7:0]                 feed;
	logic                       restart;

	// handshake
	logic item_acc, scan_acc, load_acc, replay_go, room2, pop;

	// per byte decisions
	logic                       region_start;
	logic                       found_eff;
	logic [IW-1:0]              len_m1;
	logic [mps_pkg::ADDR_W-1:0] addr_cur;
	logic [mps_pkg::ADDR_W-1:0] hit_addr;
	logic [mps_pkg::ADDR_W-1:0] end_addr;
	logic                       hit;
	logic                       in_fill;
	logic [FW-1:0]              fill_base;
	logic [FW-1:0]              fill_new;
	logic                       load_wr;

	mps_pkg::result_t match_word, end_word, word0, head;
	logic             push0, push1;

	assign cfg_ready = 1'b1;

	// a waiting scan byte cannot be taken while the match bits are stale
	assign item_stall = replay_q || !room2 || (dirty_q && command == mps_pkg::CMD_SCAN);
	assign item_acc   = item_valid && !item_stall;
	assign scan_acc   = item_acc && command == mps_pkg::CMD_SCAN;
	assign load_acc   = item_acc && command == mps_pkg::CMD_LOAD;
	assign replay_go  = dirty_q && !replay_q && item_valid && command == mps_pkg::CMD_SCAN;
	assign load_wr    = load_acc && (load_idx_q < FW'(MAX_PATTERN));

	// effective length minus one, zero reads as one and large values saturate
	always_comb begin
		if (pattern_length_q == '0) begin
			len_m1 = '0;
		end else if (32'(pattern_length_q) > 32'(MAX_PATTERN)) begin
			len_m1 = IW'(MAX_PATTERN - 1);
		end else begin
			len_m1 = IW'(32'(pattern_length_q) - 32'd1);
		end
	end

	assign region_start = !active_q;
	assign found_eff    = found_q && !region_start;
	assign addr_cur     = region_start ? region_base_q : scan_addr_q;
	assign hit_addr     = addr_cur - 32'(len_m1);

	// full pattern seen when the prefix bit at position length-1 is set
	assign hit = scan_acc && mat_next[len_m1] && (report_all_q || !found_eff);

	always_comb begin
		if (hit) begin
			end_addr = hit_addr;
		end else if (found_eff) begin
			end_addr = hit_addr_q;
		end else begin
			end_addr = mps_pkg::NO_ADDRESS;
		end
	end

	// during a rebuild the oldest window byte comes back in at the front;
	// bytes older than the fill count must not start a prefix
	assign in_fill = ((FW+1)'(rep_cnt_q) + (FW+1)'(fill_q)) >= (FW+1)'(MAX_PATTERN);
	assign feed    = replay_q ? win[MAX_PATTERN-1] : data_byte;
	assign restart = (scan_acc && region_start) || (replay_q && rep_cnt_q == '0);

	assign ctrl.shift = scan_acc || replay_q;
	assign ctrl.clear = (hit && report_all_q) || (replay_q && !in_fill);

	// window fill count, saturating, emptied by a region start or a hit in report-all mode
	assign fill_base = region_start ? '0 : fill_q;
	always_comb begin
		if (hit && report_all_q) begin
			fill_new = '0;
		end else if (fill_base == FW'(MAX_PATTERN)) begin
			fill_new = fill_base;
		end else begin
			fill_new = fill_base + FW'(1);
		end
	end

	// cell chain
	genvar gi;
	generate
		for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
			if (gi == 0) begin : g_head
				assign chain_in[gi] = 1'b1;
			end else begin : g_body
				assign chain_in[gi] = mat[gi-1] & ~restart;
			end

			mps_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.feed      (feed),
				.load_en   (load_wr && load_idx_q == FW'(gi)),
				.load_byte (data_byte),
				.win_in    ((gi == 0) ? feed : win[(gi == 0) ? 0 : gi-1]),
				.mat_in    (chain_in[gi]),
				.win_q     (win[gi]),
				.mat_q     (mat[gi]),
				.mat_next  (mat_next[gi])
			);
		end
	endgenerate

	// result words; a hit on the final byte is followed by the end report
	assign match_word.kind          = mps_pkg::KIND_MATCH;
	assign match_word.match_address = hit_addr;
	assign match_word.any_found     = 1'b1;
	assign match_word.last          = !last_byte;

	assign end_word.kind          = mps_pkg::KIND_END;
	assign end_word.match_address = end_addr;
	assign end_word.any_found     = found_eff || hit;
	assign end_word.last          = 1'b1;

	assign push0 = scan_acc && (hit || last_byte);
	assign push1 = hit && last_byte;
	assign word0 = hit ? match_word : end_word;
	assign pop   = result_valid && !result_stall;

	mps_rfifo u_rfifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push0    (push0),
		.word0    (word0),
		.push1    (push1),
		.word1    (end_word),
		.pop      (pop),
		.room2    (room2),
		.nonempty (result_valid),
		.head     (head)
	);

	assign kind          = head.kind;
	assign match_address = head.match_address;
	assign any_found     = head.any_found;
	assign last          = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= mps_pkg::LEN_W'(1);
			region_base_q    <= '0;
			report_all_q     <= 1'b0;
			active_q         <= 1'b0;
			scan_addr_q      <= '0;
			fill_q           <= '0;
			found_q          <= 1'b0;
			hit_addr_q       <= mps_pkg::NO_ADDRESS;
			load_idx_q       <= '0;
			dirty_q          <= 1'b0;
			replay_q         <= 1'b0;
			rep_cnt_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					mps_pkg::CFG_PATTERN_LENGTH: begin
						pattern_length_q <= cfg_data[mps_pkg::LEN_W-1:0];
					end
					mps_pkg::CFG_REGION_BASE: begin
						region_base_q <= cfg_data[mps_pkg::ADDR_W-1:0];
					end
					mps_pkg::CFG_REPORT_ALL: begin
						report_all_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end

			// pattern loads; a change while a region runs marks the match bits stale
			if (load_acc) begin
				if (load_wr) begin
					load_idx_q <= load_idx_q + FW'(1);
					if (active_q) begin
						dirty_q <= 1'b1;
					end
				end
				if (last_byte) begin
					load_idx_q <= '0;
				end
			end

			if (scan_acc) begin
				active_q    <= !last_byte;
				scan_addr_q <= addr_cur + 32'd1;
				fill_q      <= fill_new;
				found_q     <= found_eff || hit;
				if (hit) begin
					hit_addr_q <= hit_addr;
				end else if (region_start) begin
					hit_addr_q <= mps_pkg::NO_ADDRESS;
				end
			end

			// one full rotation of the window rebuilds every prefix bit
			if (replay_go) begin
				replay_q  <= 1'b1;
				rep_cnt_q <= '0;
				dirty_q   <= 1'b0;
			end else if (replay_q) begin
				rep_cnt_q <= rep_cnt_q + IW'(1);
				if (rep_cnt_q == IW'(MAX_PATTERN - 1)) begin
					replay_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: hdl/mps_checker.sv
// mps_checker: port level checks of memory_pattern_search, with its bind
// depends on mps_pkg
module mps_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_stall,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic                       kind,
	input logic [mps_pkg::ADDR_W-1:0] match_address,
	input logic                       any_found,
	input logic                       last
);

	// an offered input word always sees a known stall
	a_stall_known: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |-> !$isunknown(item_stall))
		else $error("input stall unknown while a word is offered");

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(match_address)
			&& $stable(kind) && $stable(any_found) && $stable(last))
		else $error("result word changed while stalled");

	// the end report always closes the results of its byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == mps_pkg::KIND_END |-> last)
		else $error("end report without last");

	// a match report always claims a match
	a_match_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == mps_pkg::KIND_MATCH |-> any_found)
		else $error("match report without found flag");

	// an empty region reports no address
	a_none_addr: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == mps_pkg::KIND_END && !any_found
			|-> match_address == mps_pkg::NO_ADDRESS)
		else $error("end report of empty region carries an address");

endmodule

bind memory_pattern_search mps_checker u_mps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item_valid),
	.item_stall    (item_stall),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.kind          (kind),
	.match_address (match_address),
	.any_found     (any_found),
	.last          (last)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for memory_pattern_search, pattern load and region scan
// depends on mps_pkg and the memory_pattern_search rtl, needs no files or arguments
module testbench;

	localparam int MAX_PATTERN     = 256;
	localparam int PREDICTED       = -1;    // row has no typed expectation
	localparam int WATCHDOG_CYCLES = 5000;  // quiet cycles before giving up
	localparam int HOLD_CYCLES     = 600;   // long receiver hold-off

	// clock, reset and dut inputs, all known from time zero
	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       item_valid   = 1'b0;
	logic                       item_stall;
	logic                       command      = 1'b0;
	logic [7:0]                 data_byte    = 8'h00;
	logic                       last_byte    = 1'b0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic                       kind;
	logic [mps_pkg::ADDR_W-1:0] match_address;
	logic                       any_found;
	logic                       last;
	logic                       cfg_valid    = 1'b0;
	logic                       cfg_ready;
	logic [mps_pkg::CFG_IW-1:0] cfg_index    = '0;
	logic [mps_pkg::CFG_DW-1:0] cfg_data     = '0;

	memory_pattern_search #(.MAX_PATTERN(MAX_PATTERN)) i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle rates in percent, set per phase by the stimulus process
	int send_pct = 0;
	int recv_pct = 0;
	// long hold-off request, picked up by the receiver process
	int hold_request = 0;
	int hold_left    = 0;

	// search predictor state and its copy of the registers
	logic [7:0]                 pattern_bytes [MAX_PATTERN];
	logic [7:0]                 recent_bytes [MAX_PATTERN];  // index 0 is the newest byte
	int unsigned                recent_count;
	int unsigned                load_slot    = 0;
	logic [mps_pkg::ADDR_W-1:0] scan_next;
	logic [mps_pkg::ADDR_W-1:0] latest_hit;
	logic                       region_hit;
	logic                       region_open  = 1'b0;
	logic [mps_pkg::LEN_W-1:0]  cfg_len      = 9'd1;
	logic [mps_pkg::ADDR_W-1:0] cfg_base     = '0;
	logic                       cfg_all      = 1'b0;

	// words produced by the last predicted item
	mps_pkg::result_t step_reports [2];
	int               step_count;

	// reports still owed by the dut, oldest first
	mps_pkg::result_t report_queue [$];
	int               mismatch_count = 0;

	// what the stimulus believes sits at the head of the pattern store
	logic [7:0] pattern_mirror [MAX_PATTERN];

	// directed table
	typedef struct {
		logic                       is_cfg;
		logic [mps_pkg::CFG_IW-1:0] reg_index;
		logic [mps_pkg::CFG_DW-1:0] reg_value;
		logic                       cmd;
		logic [7:0]                 value;
		logic                       fin;
		int                         n_typed;
		mps_pkg::result_t           t0;
		mps_pkg::result_t           t1;
	} dir_row_t;

	dir_row_t directed_rows [$];

	function automatic int effective_span(input logic [mps_pkg::LEN_W-1:0] len);
		if (len == 0) begin
			return 1;
		end
		if (len > MAX_PATTERN) begin
			return MAX_PATTERN;
		end
		return len;
	endfunction

	function automatic mps_pkg::result_t report_word(input logic k,
		input logic [mps_pkg::ADDR_W-1:0] a, input logic f, input logic l);
		return {k, a, f, l};
	endfunction

	// one input word through the search: loads fill the store, scans shift the
	// window and compare its newest span bytes against the pattern
	function automatic void search_step(input logic cmd, input logic [7:0] b, input logic fin);
		int unsigned                span;
		logic                       hit;
		logic [mps_pkg::ADDR_W-1:0] at;
		step_count = 0;
		if (cmd == mps_pkg::CMD_LOAD) begin
			// overflow loads are dropped until the closing byte rewinds the slot
			if (load_slot < MAX_PATTERN) begin
				pattern_bytes[load_slot] = b;
				load_slot++;
			end
			if (fin) begin
				load_slot = 0;
			end
			return;
		end
		// region start: fresh window, base address, no hit yet
		if (!region_open) begin
			region_open = 1'b1;
			scan_next   = cfg_base;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				recent_bytes[i] = 8'h00;
			end
			recent_count = 0;
			region_hit   = 1'b0;
			latest_hit   = mps_pkg::NO_ADDRESS;
		end
		at        = scan_next;
		scan_next = at + 1;  // wraps at 2^32
		for (int i = MAX_PATTERN - 1; i > 0; i--) begin
			recent_bytes[i] = recent_bytes[i-1];
		end
		recent_bytes[0] = b;
		if (recent_count < MAX_PATTERN) begin
			recent_count++;
		end
		span = effective_span(cfg_len);
		hit  = (recent_count >= span);
		for (int i = 0; i < span; i++) begin
			if (recent_bytes[span-1-i] !== pattern_bytes[i]) begin
				hit = 1'b0;
			end
		end
		if (hit && (cfg_all || !region_hit)) begin
			latest_hit = at - (span - 1);
			region_hit = 1'b1;
			step_reports[step_count] = report_word(mps_pkg::KIND_MATCH, latest_hit, 1'b1, !fin);
			step_count++;
			// report-all mode empties the window so hits never overlap
			if (cfg_all) begin
				recent_count = 0;
			end
		end
		if (fin) begin
			step_reports[step_count] = report_word(mps_pkg::KIND_END,
				region_hit ? latest_hit : mps_pkg::NO_ADDRESS, region_hit, 1'b1);
			step_count++;
			region_open = 1'b0;
		end
	endfunction

	function automatic void cfg_row(input logic [mps_pkg::CFG_IW-1:0] idx,
		input logic [mps_pkg::CFG_DW-1:0] val);
		dir_row_t r;
		r           = '{default: '0};
		r.is_cfg    = 1'b1;
		r.reg_index = idx;
		r.reg_value = val;
		directed_rows.push_back(r);
	endfunction

	function automatic void word_row(input logic c, input logic [7:0] b, input logic fin,
		input int n, input mps_pkg::result_t t0, input mps_pkg::result_t t1);
		dir_row_t r;
		r         = '{default: '0};
		r.cmd     = c;
		r.value   = b;
		r.fin     = fin;
		r.n_typed = n;
		r.t0      = t0;
		r.t1      = t1;
		directed_rows.push_back(r);
	endfunction

	// offer one word, after idle cycles drawn one by one, and hold it until taken;
	// valid stays high afterwards so back-to-back words need no toggle
	task automatic send_word(input logic c, input logic [7:0] b, input logic fin,
		input int n_typed, input mps_pkg::result_t t0, input mps_pkg::result_t t1);
		while ($urandom_range(0, 99) < send_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		command    <= c;
		data_byte  <= b;
		last_byte  <= fin;
		do @(posedge clk); while (item_stall);
		search_step(c, b, fin);
		if (n_typed == PREDICTED) begin
			for (int i = 0; i < step_count; i++) begin
				report_queue.push_back(step_reports[i]);
			end
		end else begin
			if (n_typed > 0) begin
				report_queue.push_back(t0);
			end
			if (n_typed > 1) begin
				report_queue.push_back(t1);
			end
		end
	endtask

	task automatic send_plain(input logic c, input logic [7:0] b, input logic fin);
		send_word(c, b, fin, PREDICTED, '0, '0);
	endtask

	// drop valid, wait for every owed report, then cover a window rotation
	// that a mid-region load may still have running
	task automatic settle();
		item_valid <= 1'b0;
		while (report_queue.size() != 0) @(posedge clk);
		repeat (MAX_PATTERN + 8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mps_pkg::CFG_IW-1:0] idx,
		input logic [mps_pkg::CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			mps_pkg::CFG_PATTERN_LENGTH: cfg_len = val[mps_pkg::LEN_W-1:0];
			mps_pkg::CFG_REGION_BASE:    cfg_base = val;
			mps_pkg::CFG_REPORT_ALL:     cfg_all = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// fresh pattern of n bytes, drawn from a small alphabet so scans hit often
	task automatic load_pattern(input int n);
		logic [7:0] b;
		for (int j = 0; j < n; j++) begin
			b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(0, 3));
			pattern_mirror[j] = b;
			send_plain(mps_pkg::CMD_LOAD, b, j == n - 1);
		end
	endtask

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_pct);
		end
	end

	// report checker: every taken word against the oldest expectation
	always @(posedge clk) begin
		mps_pkg::result_t got;
		mps_pkg::result_t want;
		if (result_valid && !result_stall) begin
			got = {kind, match_address, any_found, last};
			if (report_queue.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("unexpected word: kind %0d addr %h found %0d last %0d",
						got.kind, got.match_address, got.any_found, got.last);
				end
				mismatch_count++;
			end else begin
				want = report_queue.pop_front();
				if (got.kind !== want.kind || got.match_address !== want.match_address ||
					got.any_found !== want.any_found || got.last !== want.last) begin
					if (mismatch_count < 10) begin
						$display("mismatch: expected kind %0d addr %h found %0d last %0d",
							want.kind, want.match_address, want.any_found, want.last);
						$display("          got      kind %0d addr %h found %0d last %0d",
							got.kind, got.match_address, got.any_found, got.last);
					end
					mismatch_count++;
				end
			end
		end
	end

	// watchdog: ends the run after a long stretch with no word moving anywhere
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("status: fail");
		$finish;
	end

	// stimulus
	initial begin
		int                         eff;
		int                         rlen;
		int                         reload_at;
		int                         phase_sent;
		int                         pick;
		logic [mps_pkg::CFG_DW-1:0] len_val;
		logic [mps_pkg::CFG_DW-1:0] base_val;
		logic [7:0]                 b;
		logic [7:0]                 region_q [$];

		// directed table: typed expectations where they are obvious
		// one-byte pattern 00 right after reset, a one-byte region that hits it, then one with no hit
		word_row(mps_pkg::CMD_LOAD, 8'h00, 1'b1, 0, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'h00, 1'b1, 2,
			report_word(mps_pkg::KIND_MATCH, 32'h0, 1'b1, 1'b0),
			report_word(mps_pkg::KIND_END, 32'h0, 1'b1, 1'b1));
		word_row(mps_pkg::CMD_SCAN, 8'hff, 1'b1, 1,
			report_word(mps_pkg::KIND_END, mps_pkg::NO_ADDRESS, 1'b0, 1'b1), '0);
		// zero length acts as one, base just below the wrap, report all
		cfg_row(mps_pkg::CFG_PATTERN_LENGTH, 32'd0);
		cfg_row(mps_pkg::CFG_REGION_BASE, 32'hffff_fffe);
		cfg_row(mps_pkg::CFG_REPORT_ALL, 32'd1);
		word_row(mps_pkg::CMD_LOAD, 8'hff, 1'b1, 0, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'hff, 1'b0, 1,
			report_word(mps_pkg::KIND_MATCH, 32'hffff_fffe, 1'b1, 1'b1), '0);
		word_row(mps_pkg::CMD_SCAN, 8'hff, 1'b0, 1,
			report_word(mps_pkg::KIND_MATCH, 32'hffff_ffff, 1'b1, 1'b1), '0);
		// address wraps to zero, hit on the closing byte comes before the end report
		word_row(mps_pkg::CMD_SCAN, 8'hff, 1'b1, 2,
			report_word(mps_pkg::KIND_MATCH, 32'h0, 1'b1, 1'b0),
			report_word(mps_pkg::KIND_END, 32'h0, 1'b1, 1'b1));
		// three byte pattern, first-only mode, two occurrences
		cfg_row(mps_pkg::CFG_PATTERN_LENGTH, 32'd3);
		cfg_row(mps_pkg::CFG_REGION_BASE, 32'h100);
		cfg_row(mps_pkg::CFG_REPORT_ALL, 32'd0);
		word_row(mps_pkg::CMD_LOAD, 8'ha5, 1'b0, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_LOAD, 8'h5a, 1'b0, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_LOAD, 8'hc3, 1'b1, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'h00, 1'b0, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'ha5, 1'b0, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'h5a, 1'b0, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'hc3, 1'b0, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'ha5, 1'b0, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'h5a, 1'b0, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'hc3, 1'b1, PREDICTED, '0, '0);
		// shorter span in report-all mode, then length changed mid-region
		cfg_row(mps_pkg::CFG_PATTERN_LENGTH, 32'd2);
		cfg_row(mps_pkg::CFG_REPORT_ALL, 32'd1);
		word_row(mps_pkg::CMD_SCAN, 8'ha5, 1'b0, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'h5a, 1'b0, PREDICTED, '0, '0);
		cfg_row(mps_pkg::CFG_PATTERN_LENGTH, 32'd1);
		// pattern reload while the region is open keeps the scan state
		word_row(mps_pkg::CMD_LOAD, 8'h5a, 1'b1, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'h5a, 1'b0, PREDICTED, '0, '0);
		word_row(mps_pkg::CMD_SCAN, 8'h5a, 1'b1, PREDICTED, '0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pct = 10;
		recv_pct = 68;
		foreach (directed_rows[r]) begin
			if (directed_rows[r].is_cfg) begin
				if (r == 0 || !directed_rows[r-1].is_cfg) begin
					settle();
				end
				write_reg(directed_rows[r].reg_index, directed_rows[r].reg_value);
			end else begin
				send_word(directed_rows[r].cmd, directed_rows[r].value, directed_rows[r].fin,
					directed_rows[r].n_typed, directed_rows[r].t0, directed_rows[r].t1);
			end
		end
		settle();

		// full-width pattern: overflow loads past the store end are dropped,
		// then a region whose closing byte completes a 256 byte hit
		write_reg(mps_pkg::CFG_PATTERN_LENGTH, MAX_PATTERN);
		write_reg(mps_pkg::CFG_REGION_BASE, $urandom());
		write_reg(mps_pkg::CFG_REPORT_ALL, 32'd0);
		for (int i = 0; i < MAX_PATTERN + 2; i++) begin
			b = 8'($urandom_range(0, 255));
			if (i < MAX_PATTERN) begin
				pattern_mirror[i] = b;
			end
			send_plain(mps_pkg::CMD_LOAD, b, i == MAX_PATTERN + 1);
		end
		repeat ($urandom_range(0, 3)) begin
			send_plain(mps_pkg::CMD_SCAN, 8'($urandom_range(0, 255)), 1'b0);
		end
		for (int i = 0; i < MAX_PATTERN; i++) begin
			send_plain(mps_pkg::CMD_SCAN, pattern_mirror[i], i == MAX_PATTERN - 1);
		end
		settle();

		// random phases, short patterns are loaded afresh, longer spans reuse the store
		for (int p = 1; p <= 12; p++) begin
			// sender light / receiver heavy, then swapped, then no idling
			case ((p - 1) / 4)
				0: begin
					send_pct = 10;
					recv_pct = 68;
				end
				1: begin
					send_pct = 68;
					recv_pct = 10;
				end
				default: begin
					send_pct = 0;
					recv_pct = 0;
				end
			endcase

			pick = $urandom_range(0, 9);
			case (pick)
				0: len_val = 0;
				1: len_val = MAX_PATTERN;
				2: len_val = 511;  // saturates to the store size
				3: len_val = $urandom_range(0, 511);
				default: len_val = $urandom_range(1, 6);
			endcase
			pick = $urandom_range(0, 5);
			case (pick)
				0: base_val = 32'h0;
				1: base_val = 32'hffff_ffff;
				2: base_val = 32'hffff_ffff - $urandom_range(0, 8);
				default: base_val = $urandom();
			endcase
			write_reg(mps_pkg::CFG_PATTERN_LENGTH, len_val);
			write_reg(mps_pkg::CFG_REGION_BASE, base_val);
			write_reg(mps_pkg::CFG_REPORT_ALL, $urandom_range(0, 1));
			eff = effective_span(len_val[mps_pkg::LEN_W-1:0]);
			if (eff <= 8) begin
				load_pattern(eff);
			end

			// receiver sits still while the sender keeps pushing, so the
			// result queue fills and the input stalls
			if (p == 2) begin
				hold_request = HOLD_CYCLES;
			end

			phase_sent = 0;
			while (phase_sent < 15) begin
				// region of planted copies, pattern-alphabet bytes and noise
				region_q.delete();
				rlen = $urandom_range(1, 20);
				while (region_q.size() < rlen) begin
					if (eff <= 8 && $urandom_range(0, 3) == 0) begin
						for (int j = 0; j < eff; j++) begin
							region_q.push_back(pattern_mirror[j]);
						end
					end else if ($urandom_range(0, 1)) begin
						region_q.push_back(pattern_mirror[$urandom_range(0, eff - 1)]);
					end else begin
						region_q.push_back(8'($urandom_range(0, 255)));
					end
				end
				// now and then a new pattern lands in the middle of the region
				reload_at = (eff <= 8 && $urandom_range(0, 7) == 0) ?
					$urandom_range(0, region_q.size() - 1) : -1;
				foreach (region_q[j]) begin
					if (j == reload_at) begin
						load_pattern(eff);
					end
					send_plain(mps_pkg::CMD_SCAN, region_q[j], j == region_q.size() - 1);
				end
				phase_sent += region_q.size();
			end
			// sometimes leave a region open across the next register writes
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					send_plain(mps_pkg::CMD_SCAN, 8'($urandom_range(0, 255)), 1'b0);
				end
			end
			// sender waits here until every owed report is back
			settle();
		end

		if (mismatch_count == 0 && report_queue.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
